### rtl/dnpt_pkg.sv
package dnpt_pkg;

    // Field widths
    localparam int DEPTH_W    = 15;
    localparam int COORD_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int CENTER_W   = 10;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int Q_SHIFT    = 24;

    localparam int MAX_DIM_DEF = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROJECTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_X_CENTER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_CENTER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT  = 3'd7;

    // Reset values
    localparam logic                RST_PROJECTIVE = 1'b1;
    localparam logic [DIM_W-1:0]    RST_WIDTH      = 11'd640;
    localparam logic [DIM_W-1:0]    RST_HEIGHT     = 11'd480;
    localparam logic [GAIN_W-1:0]   RST_X_GAIN     = 16'd29135;
    localparam logic [GAIN_W-1:0]   RST_Y_GAIN     = 16'd29137;
    localparam logic [CENTER_W-1:0] RST_X_CENTER   = 10'd320;
    localparam logic [CENTER_W-1:0] RST_Y_CENTER   = 10'd240;
    localparam logic [DEPTH_W-1:0]  RST_FAR_LIMIT  = 15'd20000;

    localparam logic KIND_CLOUD = 1'b0;
    localparam logic KIND_FG    = 1'b1;

    typedef struct packed {
        logic                projective;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [GAIN_W-1:0]   x_gain;
        logic [GAIN_W-1:0]   y_gain;
        logic [CENTER_W-1:0] x_center;
        logic [CENTER_W-1:0] y_center;
        logic [DEPTH_W-1:0]  far_limit;
    } t_cfg;

    typedef struct packed {
        logic load;     // latch pixel, apply frame start
        logic mul1;     // offset times depth
        logic mul2;     // times gain
        logic cloud;    // emit cloud point, update nearest, advance raster
        logic fg;       // emit foreground point, rearm nearest
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic z_nonzero;
        logic end_frame;
    } t_status;

endpackage

### rtl/dnpt_ctrl.sv
module dnpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  dnpt_pkg::t_status i_status,
    output dnpt_pkg::t_cmd    o_cmd
);
    import dnpt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_MUL2 = 5'b00100,
        S_EMIT = 5'b01000,
        S_FG   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // an empty pixel needs no output slot
                if (i_status.out_free || !i_status.z_nonzero) begin
                    o_cmd.cloud = 1'b1;
                    n_state     = i_status.end_frame ? S_FG : S_IDLE;
                end
            end
            S_FG: begin
                if (i_status.out_free) begin
                    o_cmd.fg = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_MUL1))
        else $error("accepted pixel did not start the multiply stages");

    a_end_goes_fg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.cloud && i_status.end_frame) |=> (r_state == S_FG))
        else $error("frame end did not lead to the foreground point");

    a_fg_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fg |-> i_status.out_free)
        else $error("foreground point issued with output slot full");

endmodule

### rtl/dnpt_datapath.sv
module dnpt_datapath #(
    parameter int MAX_DIM = dnpt_pkg::MAX_DIM_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dnpt_pkg::t_cmd                        i_cmd,
    output dnpt_pkg::t_status                     o_status,
    input  dnpt_pkg::t_cfg                        i_cfg,
    input  logic [dnpt_pkg::DEPTH_W-1:0]          i_depth,
    input  logic                                  i_frame_start,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_kind,
    output logic signed [dnpt_pkg::COORD_W-1:0]   o_point_x,
    output logic signed [dnpt_pkg::COORD_W-1:0]   o_point_y,
    output logic [dnpt_pkg::DEPTH_W-1:0]          o_point_z,
    output logic                                  o_last
);
    import dnpt_pkg::*;

    localparam int CW  = $clog2(MAX_DIM);
    localparam int XW  = (DIM_W > CW + 1) ? DIM_W : CW + 1;
    localparam int AW  = (CW > CENTER_W) ? CW : CENTER_W;
    localparam int P1W = AW + DEPTH_W;
    localparam int P2W = P1W + GAIN_W;
    localparam int SW  = P2W + 1;
    localparam int QW  = SW - Q_SHIFT;

    // raster and nearest state
    logic [CW-1:0]              r_col, r_row;
    logic signed [COORD_W-1:0]  r_nx, r_ny;
    logic [DEPTH_W-1:0]         r_nz;

    // pixel stages
    logic [DEPTH_W-1:0]         r_z;
    logic                       r_end_row, r_end_frame;
    logic                       r_neg_x, r_neg_y;
    logic [P1W-1:0]             r_p1x, r_p1y;
    logic [P2W-1:0]             r_p2x, r_p2y;

    // output slot
    logic                       r_out_valid;
    logic                       r_kind, r_last;
    logic signed [COORD_W-1:0]  r_px, r_py;
    logic [DEPTH_W-1:0]         r_pz;

    logic [CW-1:0]              wm1, hm1;
    logic [AW-1:0]              mag_x, mag_y;
    logic signed [COORD_W-1:0]  px, py;
    logic                       z_nz, take, load_cloud;

    function automatic logic [CW-1:0] dim_m1(input logic [DIM_W-1:0] v);
        logic [XW-1:0] vx;
        vx = XW'(v);
        if (vx == '0) begin
            return '0;
        end else if (vx > XW'(MAX_DIM)) begin
            return CW'(MAX_DIM - 1);
        end else begin
            return CW'(vx - XW'(1));
        end
    endfunction

    // floor of signed product / 2^24, saturated to 16 bits
    function automatic logic signed [COORD_W-1:0] scale_sat(input logic neg,
                                                            input logic [P2W-1:0] p);
        logic [SW-1:0] s;
        logic [QW-1:0] q;
        s = {1'b0, p} + (neg ? SW'((1 << Q_SHIFT) - 1) : SW'(0));
        q = QW'(s >> Q_SHIFT);
        if (!neg) begin
            return (q > QW'(32767)) ? 16'sh7FFF : $signed(q[COORD_W-1:0]);
        end else begin
            return (q > QW'(32768)) ? 16'sh8000 : $signed(COORD_W'(QW'(0) - q));
        end
    endfunction

    assign wm1  = dim_m1(i_cfg.width);
    assign hm1  = dim_m1(i_cfg.height);
    assign z_nz = (r_z != '0);

    assign mag_x = (AW'(r_col) >= AW'(i_cfg.x_center)) ? AW'(r_col) - AW'(i_cfg.x_center)
                                                      : AW'(i_cfg.x_center) - AW'(r_col);
    assign mag_y = (AW'(r_row) >= AW'(i_cfg.y_center)) ? AW'(r_row) - AW'(i_cfg.y_center)
                                                      : AW'(i_cfg.y_center) - AW'(r_row);

    always_comb begin
        if (i_cfg.projective) begin
            px = $signed(COORD_W'(r_col));
            py = $signed(COORD_W'(r_row));
        end else begin
            px = scale_sat(r_neg_x, r_p2x);
            py = scale_sat(r_neg_y, r_p2y);
        end
    end

    assign take       = r_out_valid && !i_stall;
    assign load_cloud = i_cmd.cloud && z_nz;

    assign o_status.out_free  = !r_out_valid || !i_stall;
    assign o_status.z_nonzero = z_nz;
    assign o_status.end_frame = r_end_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_nx        <= '0;
            r_ny        <= '0;
            r_nz        <= RST_FAR_LIMIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_frame_start) begin
                r_col <= '0;
                r_row <= '0;
                r_nz  <= i_cfg.far_limit;
            end
            if (i_cmd.cloud) begin
                if (z_nz && (r_z < r_nz)) begin
                    r_nx <= px;
                    r_ny <= py;
                    r_nz <= r_z;
                end
                // advance the raster
                if (r_end_frame) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (r_end_row) begin
                    r_col <= '0;
                    r_row <= (r_row == CW'(MAX_DIM - 1)) ? '0 : r_row + CW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.fg) begin
                r_nz <= i_cfg.far_limit;
            end
            if (load_cloud || i_cmd.fg) begin
                r_out_valid <= 1'b1;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z <= i_depth;
        end
        if (i_cmd.mul1) begin
            r_end_row   <= (r_col >= wm1);
            r_end_frame <= (r_col >= wm1) && (r_row >= hm1);
            r_neg_x     <= (AW'(r_col) < AW'(i_cfg.x_center));
            r_neg_y     <= (AW'(r_row) < AW'(i_cfg.y_center));
            r_p1x       <= P1W'(mag_x) * P1W'(r_z);
            r_p1y       <= P1W'(mag_y) * P1W'(r_z);
        end
        if (i_cmd.mul2) begin
            r_p2x <= P2W'(r_p1x) * P2W'(i_cfg.x_gain);
            r_p2y <= P2W'(r_p1y) * P2W'(i_cfg.y_gain);
        end
        if (load_cloud) begin
            r_kind <= KIND_CLOUD;
            r_px   <= px;
            r_py   <= py;
            r_pz   <= r_z;
            r_last <= !r_end_frame;
        end else if (i_cmd.fg) begin
            r_kind <= KIND_FG;
            r_px   <= r_nx;
            r_py   <= r_ny;
            r_pz   <= r_nz;
            r_last <= 1'b1;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_kind    = r_kind;
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_point_z = r_pz;
    assign o_last    = r_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_cloud || i_cmd.fg) |-> (!r_out_valid || !i_stall))
        else $error("output slot overwritten before transfer");

    a_fg_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_FG)) |-> r_last)
        else $error("foreground point not marked last");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < MAX_DIM) && (32'(r_col) < MAX_DIM))
        else $error("raster counter out of range");

endmodule

### rtl/depth_nearest_point_tracker_core.sv
// Channel   | Direction | Handshake            | Payload
// pixel in  | input     | i_valid / o_stall    | i_depth, i_frame_start
// point out | output    | o_valid / i_stall    | o_kind, o_point_x/y/z, o_last
// config    | input     | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// A pixel passes from transfer to its cloud point in the output register in four steps:
// accept, offset times depth, times gain, round and emit. A frame's last pixel
// takes one more step for the foreground point; the next pixel is taken after that.
// The two multiplier stages are registered; one pixel is in flight at a time.
// A stalled output holds a nonzero pixel's emit step until the register frees.
// Synchronous active-low reset restores the register defaults and clears the raster.
module depth_nearest_point_tracker_core #(
    parameter int MAX_DIM = dnpt_pkg::MAX_DIM_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [dnpt_pkg::DEPTH_W-1:0]          i_depth,
    input  logic                                  i_frame_start,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_kind,
    output logic signed [dnpt_pkg::COORD_W-1:0]   o_point_x,
    output logic signed [dnpt_pkg::COORD_W-1:0]   o_point_y,
    output logic [dnpt_pkg::DEPTH_W-1:0]          o_point_z,
    output logic                                  o_last,
    input  logic                                  i_cfg_we,
    input  logic [dnpt_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dnpt_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dnpt_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.projective <= RST_PROJECTIVE;
            r_cfg.width      <= RST_WIDTH;
            r_cfg.height     <= RST_HEIGHT;
            r_cfg.x_gain     <= RST_X_GAIN;
            r_cfg.y_gain     <= RST_Y_GAIN;
            r_cfg.x_center   <= RST_X_CENTER;
            r_cfg.y_center   <= RST_Y_CENTER;
            r_cfg.far_limit  <= RST_FAR_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROJECTIVE: r_cfg.projective <= i_cfg_data[0];
                CFG_WIDTH:      r_cfg.width      <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:     r_cfg.height     <= i_cfg_data[DIM_W-1:0];
                CFG_X_GAIN:     r_cfg.x_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_Y_GAIN:     r_cfg.y_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_X_CENTER:   r_cfg.x_center   <= i_cfg_data[CENTER_W-1:0];
                CFG_Y_CENTER:   r_cfg.y_center   <= i_cfg_data[CENTER_W-1:0];
                CFG_FAR_LIMIT:  r_cfg.far_limit  <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    dnpt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dnpt_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg         (r_cfg),
        .i_depth       (i_depth),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z),
        .o_last        (o_last)
    );

endmodule
